@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define STOT_ASSERT_PROP(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
`define STOT_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`else
`define STOT_ASSERT_PROP(lbl, ck, rn, prop, msg)
`define STOT_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`endif

`endif

@@ rtl/stot_pkg.sv @@
// ----------------------------------------------------------------------------
// stot_pkg
// Types and constants shared by the tile overlap trimmer modules.
// ----------------------------------------------------------------------------
package stot_pkg;

    localparam int FIELD_BITS    = 16;
    localparam int LEN_BITS      = 16;
    localparam int CAND_BITS     = 17;
    localparam int VERDICT_BITS  = 3;
    localparam logic [LEN_BITS-1:0] MIN_LEN_RESET = 16'd8;

    typedef enum logic [VERDICT_BITS-1:0] {
        VERDICT_STORED  = 3'd0,
        VERDICT_TRIMMED = 3'd1,
        VERDICT_DISCARD = 3'd2,
        VERDICT_FULL    = 3'd3,
        VERDICT_CLEARED = 3'd4
    } verdict_t;

    typedef enum logic {
        FUNC_CHECK = 1'b0,
        FUNC_CLEAR = 1'b1
    } func_t;

    typedef logic [CAND_BITS-1:0] cand_pos_t;

    // A candidate on its way down the cell chain. Ends are start plus length.
    typedef struct packed {
        logic                clear;
        logic                trimmed;
        logic                discard;
        logic                stored;
        cand_pos_t           a;
        cand_pos_t           b;
        cand_pos_t           ea;
        cand_pos_t           eb;
        logic [LEN_BITS-1:0] len0;
    } stot_word_t;

endpackage

@@ rtl/stot_ifs.sv @@
// ----------------------------------------------------------------------------
// stot interfaces
// Valid/ready channels for candidates, results and the configuration write.
// ----------------------------------------------------------------------------
interface stot_cand_if;
    logic                             valid;
    logic                             ready;
    logic                             func;
    logic [stot_pkg::FIELD_BITS-1:0]  cand_first_pos;
    logic [stot_pkg::FIELD_BITS-1:0]  cand_second_pos;
    logic [stot_pkg::LEN_BITS-1:0]    cand_len;

    modport source (
        output valid, func, cand_first_pos, cand_second_pos, cand_len,
        input  ready
    );
    modport sink (
        input  valid, func, cand_first_pos, cand_second_pos, cand_len,
        output ready
    );
endinterface

interface stot_res_if;
    logic                              valid;
    logic                              ready;
    logic [stot_pkg::VERDICT_BITS-1:0] verdict;
    logic [stot_pkg::FIELD_BITS-1:0]   out_first_pos;
    logic [stot_pkg::FIELD_BITS-1:0]   out_second_pos;
    logic [stot_pkg::LEN_BITS-1:0]     out_len;

    modport source (
        output valid, verdict, out_first_pos, out_second_pos, out_len,
        input  ready
    );
    modport sink (
        input  valid, verdict, out_first_pos, out_second_pos, out_len,
        output ready
    );
endinterface

interface stot_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [stot_pkg::LEN_BITS-1:0] min_match_len;

    modport source (
        output valid, min_match_len,
        input  ready
    );
    modport sink (
        input  valid, min_match_len,
        output ready
    );
endinterface

@@ rtl/stot_stage.sv @@
// ----------------------------------------------------------------------------
// stot_stage
// One registered step that trims a candidate against one tile on one sequence.
// ----------------------------------------------------------------------------
module stot_stage #(
    parameter int POS_BITS = 16,
    parameter bit SECOND   = 1'b0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_vld,
    input  stot_pkg::stot_word_t              in_word,
    input  logic                              tile_vld,
    input  logic [POS_BITS-1:0]               tile_start,
    input  logic [((POS_BITS > stot_pkg::LEN_BITS) ?
                   POS_BITS : stot_pkg::LEN_BITS):0] tile_end,
    input  logic [stot_pkg::LEN_BITS-1:0]     min_len,
    output logic                              out_vld,
    output stot_pkg::stot_word_t              out_word
);

    localparam int EW = ((POS_BITS > stot_pkg::LEN_BITS) ?
                         POS_BITS : stot_pkg::LEN_BITS) + 1;
    localparam int CB = stot_pkg::CAND_BITS;

    logic                 vld_reg;
    stot_pkg::stot_word_t word_reg;
    stot_pkg::stot_word_t word_next;

    stot_pkg::cand_pos_t x, ex, y, ey;
    stot_pkg::cand_pos_t x_new, ex_new, y_new, ey_new;
    logic [EW-1:0] xe, exe, tse, mine;
    logic [EW-1:0] head_len, tail_len, head_shift, tail_cut;
    logic          live, head, tail;

    always_comb
    begin
        x  = SECOND ? in_word.b  : in_word.a;
        ex = SECOND ? in_word.eb : in_word.ea;
        y  = SECOND ? in_word.a  : in_word.b;
        ey = SECOND ? in_word.ea : in_word.eb;

        xe   = EW'(x);
        exe  = EW'(ex);
        tse  = EW'(tile_start);
        mine = EW'(min_len);

        live = tile_vld && !in_word.clear && !in_word.discard && !in_word.stored;
        head = (xe >= tse) && (xe < tile_end);
        tail = (exe > tse) && (exe < tile_end);

        head_len   = exe - tile_end;
        head_shift = tile_end - xe;
        tail_len   = tse - xe;
        tail_cut   = exe - tse;

        word_next = in_word;
        x_new  = x;
        ex_new = ex;
        y_new  = y;
        ey_new = ey;

        if (live)
        begin
            priority if (head)
            begin
                if ((tile_end > exe) || (head_len < mine))
                begin
                    word_next.discard = 1'b1;
                end
                else
                begin
                    x_new = tile_end[CB-1:0];
                    y_new = y + head_shift[CB-1:0];
                    word_next.trimmed = 1'b1;
                end
            end
            else if (tail)
            begin
                if (tail_len < mine)
                begin
                    word_next.discard = 1'b1;
                end
                else
                begin
                    ex_new = tse[CB-1:0];
                    ey_new = ey - tail_cut[CB-1:0];
                    word_next.trimmed = 1'b1;
                end
            end
            else
            begin
                x_new = x;
            end
        end

        if (SECOND)
        begin
            word_next.b  = x_new;
            word_next.eb = ex_new;
            word_next.a  = y_new;
            word_next.ea = ey_new;
        end
        else
        begin
            word_next.a  = x_new;
            word_next.ea = ex_new;
            word_next.b  = y_new;
            word_next.eb = ey_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg <= word_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_word = word_reg;

endmodule

@@ rtl/stot_cell.sv @@
// ----------------------------------------------------------------------------
// stot_cell
// Holds one tile and checks passing candidates against it on both sequences.
// ----------------------------------------------------------------------------
module stot_cell #(
    parameter int POS_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_vld,
    input  stot_pkg::stot_word_t          in_word,
    input  logic [stot_pkg::LEN_BITS-1:0] min_len,
    output logic                          out_vld,
    output stot_pkg::stot_word_t          out_word
);

    localparam int EW = ((POS_BITS > stot_pkg::LEN_BITS) ? POS_BITS : stot_pkg::LEN_BITS) + 1;

    logic                 tile_vld_reg;
    logic                 tile_vld_next;
    logic [POS_BITS-1:0]  start_a_reg, start_b_reg;
    logic [POS_BITS-1:0]  start_a_next, start_b_next;
    logic [EW-1:0]        end_a_reg, end_b_reg;
    logic [EW-1:0]        end_a_next, end_b_next;
    logic [EW-1:0]        a_ext, b_ext;
    logic                 live, store, clear_hit;
    stot_pkg::stot_word_t entry_word;
    stot_pkg::stot_word_t mid_word;
    logic                 mid_vld;

    // An untouched candidate that reaches the first empty cell becomes its tile.
    always_comb
    begin
        live = in_vld && !in_word.clear && !in_word.discard && !in_word.stored
               && !in_word.trimmed;
        store     = live && !tile_vld_reg;
        clear_hit = in_vld && in_word.clear;

        entry_word        = in_word;
        entry_word.stored = in_word.stored | store;

        a_ext        = EW'(in_word.a);
        b_ext        = EW'(in_word.b);
        start_a_next = a_ext[POS_BITS-1:0];
        start_b_next = b_ext[POS_BITS-1:0];
        end_a_next   = EW'(start_a_next) + EW'(in_word.len0);
        end_b_next   = EW'(start_b_next) + EW'(in_word.len0);

        priority if (clear_hit)
        begin
            tile_vld_next = 1'b0;
        end
        else if (store)
        begin
            tile_vld_next = 1'b1;
        end
        else
        begin
            tile_vld_next = tile_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            tile_vld_reg <= tile_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && store)
        begin
            start_a_reg <= start_a_next;
            start_b_reg <= start_b_next;
            end_a_reg   <= end_a_next;
            end_b_reg   <= end_b_next;
        end
    end

    stot_stage #(
        .POS_BITS (POS_BITS),
        .SECOND   (1'b0)
    ) u_first (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_vld     (in_vld),
        .in_word    (entry_word),
        .tile_vld   (tile_vld_reg),
        .tile_start (start_a_reg),
        .tile_end   (end_a_reg),
        .min_len    (min_len),
        .out_vld    (mid_vld),
        .out_word   (mid_word)
    );

    stot_stage #(
        .POS_BITS (POS_BITS),
        .SECOND   (1'b1)
    ) u_second (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_vld     (mid_vld),
        .in_word    (mid_word),
        .tile_vld   (tile_vld_reg),
        .tile_start (start_b_reg),
        .tile_end   (end_b_reg),
        .min_len    (min_len),
        .out_vld    (out_vld),
        .out_word   (out_word)
    );

endmodule

@@ rtl/string_tile_overlap_trimmer_unit.sv @@
// ----------------------------------------------------------------------------
// string_tile_overlap_trimmer_unit
// Tile table with overlap trimming, built as a chain of one cell per tile.
// ----------------------------------------------------------------------------
// The block accepts one candidate or clear word per cycle while the chain
// is not held, and returns one result word for each, in order. Every cell
// holds one tile and checks a passing candidate in a registered step for the
// first sequence, then in one for the second, so the latency is set by the
// length of the cell chain. Tiles fill the cells from the front; a clear word
// empties each cell as it passes, so earlier words still see the old table.
// The whole chain holds while a finished result is not taken.

`include "assert_macros.svh"

module string_tile_overlap_trimmer_unit #(
    parameter int MAX_TILES = 256,
    parameter int POS_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    stot_cfg_if.sink    cfg,
    stot_cand_if.sink   cand,
    stot_res_if.source  result
);

    localparam int CB = stot_pkg::CAND_BITS;
    localparam int LB = stot_pkg::LEN_BITS;
    localparam int FB = stot_pkg::FIELD_BITS;

    logic [LB-1:0]         min_len_reg;
    logic                  adv;
    stot_pkg::stot_word_t  in_word;
    stot_pkg::stot_word_t  chain_word [0:MAX_TILES];
    logic                  chain_vld  [0:MAX_TILES];

    logic                  res_vld_reg;
    stot_pkg::verdict_t    verdict_reg, verdict_next;
    logic [FB-1:0]         first_reg, first_next;
    logic [FB-1:0]         second_reg, second_next;
    logic [LB-1:0]         len_reg, len_next;
    stot_pkg::cand_pos_t   end_len;
    stot_pkg::stot_word_t  last_word;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= stot_pkg::MIN_LEN_RESET;
        end
        else if (cfg.valid)
        begin
            min_len_reg <= cfg.min_match_len;
        end
    end

    assign adv        = !res_vld_reg || result.ready;
    assign cand.ready = adv;

    always_comb
    begin
        in_word         = '0;
        in_word.clear   = (stot_pkg::func_t'(cand.func) == stot_pkg::FUNC_CLEAR);
        in_word.a       = CB'(cand.cand_first_pos);
        in_word.b       = CB'(cand.cand_second_pos);
        in_word.ea      = CB'(cand.cand_first_pos) + CB'(cand.cand_len);
        in_word.eb      = CB'(cand.cand_second_pos) + CB'(cand.cand_len);
        in_word.len0    = cand.cand_len;
    end

    assign chain_word[0] = in_word;
    assign chain_vld[0]  = cand.valid;

    for (genvar i = 0; i < MAX_TILES; i++)
    begin : g_cell
        stot_cell #(
            .POS_BITS (POS_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .in_vld   (chain_vld[i]),
            .in_word  (chain_word[i]),
            .min_len  (min_len_reg),
            .out_vld  (chain_vld[i+1]),
            .out_word (chain_word[i+1])
        );
    end

    always_comb
    begin
        last_word   = chain_word[MAX_TILES];
        end_len     = last_word.ea - last_word.a;
        first_next  = last_word.a[FB-1:0];
        second_next = last_word.b[FB-1:0];
        len_next    = end_len[LB-1:0];

        priority if (last_word.clear)
        begin
            verdict_next = stot_pkg::VERDICT_CLEARED;
        end
        else if (last_word.discard)
        begin
            verdict_next = stot_pkg::VERDICT_DISCARD;
        end
        else if (last_word.trimmed)
        begin
            verdict_next = stot_pkg::VERDICT_TRIMMED;
        end
        else if (last_word.stored)
        begin
            verdict_next = stot_pkg::VERDICT_STORED;
        end
        else
        begin
            verdict_next = stot_pkg::VERDICT_FULL;
        end

        if (last_word.clear || last_word.discard)
        begin
            first_next  = '0;
            second_next = '0;
            len_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_vld_reg <= chain_vld[MAX_TILES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            verdict_reg <= verdict_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            len_reg     <= len_next;
        end
    end

    assign result.valid          = res_vld_reg;
    assign result.verdict        = verdict_reg;
    assign result.out_first_pos  = first_reg;
    assign result.out_second_pos = second_reg;
    assign result.out_len        = len_reg;

    // A result word that is not taken stays on the port unchanged.
    `STOT_ASSERT_PROP(a_res_hold, clk, rst_n,
        (result.valid && !result.ready) |=> (result.valid
            && $stable(result.verdict) && $stable(result.out_first_pos)
            && $stable(result.out_second_pos) && $stable(result.out_len)),
        "result word changed while it was waiting")

    // Discarded and cleared results carry an all-zero candidate.
    `STOT_ASSERT_IMPL(a_zero_payload, clk, rst_n,
        result.valid && (result.verdict == stot_pkg::VERDICT_DISCARD
            || result.verdict == stot_pkg::VERDICT_CLEARED),
        result.out_first_pos == '0 && result.out_second_pos == '0 && result.out_len == '0,
        "discard or clear result has a nonzero payload")

    // A trimmed candidate is never shorter than the configured minimum.
    `STOT_ASSERT_IMPL(a_trim_min, clk, rst_n,
        result.valid && (result.verdict == stot_pkg::VERDICT_TRIMMED),
        result.out_len >= min_len_reg,
        "trimmed result is below the minimum length")

endmodule

@@ bench/tb_string_tile_overlap_trimmer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_string_tile_overlap_trimmer_unit
// Self-checking bench for the tile overlap trimmer. Candidate, clear and
// configuration words are driven from a queue with random gaps, results are
// taken with random stalls, and every result is compared with a prediction
// kept in order from a behavioral copy of the tile table.
// ----------------------------------------------------------------------------
module tb_string_tile_overlap_trimmer_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TILE_SLOTS = 256;
    localparam int CHAIN_CYCLES = 2 * TILE_SLOTS + 1;
    localparam int FB = stot_pkg::FIELD_BITS;
    localparam int LB = stot_pkg::LEN_BITS;

    typedef enum {
        WORD_CAND,
        WORD_CFG,
        WORD_HOLD
    } word_kind_t;

    typedef struct {
        word_kind_t      kind;
        stot_pkg::func_t func;
        logic [FB-1:0]   first_pos;
        logic [FB-1:0]   second_pos;
        logic [LB-1:0]   len;
    } stim_word_t;

    typedef struct {
        stot_pkg::verdict_t verdict;
        logic [FB-1:0]      first_pos;
        logic [FB-1:0]      second_pos;
        logic [LB-1:0]      len;
    } tile_result_t;

    logic clk;
    logic rst_n;

    stot_cfg_if  cfg_bus ();
    stot_cand_if cand_bus ();
    stot_res_if  res_bus ();

    string_tile_overlap_trimmer_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .cand   (cand_bus),
        .result (res_bus)
    );

    stim_word_t   word_queue[$];
    tile_result_t pending_results[$];

    logic [FB-1:0] kept_first [TILE_SLOTS];
    logic [FB-1:0] kept_second [TILE_SLOTS];
    logic [LB-1:0] kept_len [TILE_SLOTS];
    int            kept_count;
    logic [LB-1:0] min_tile_len;

    int mismatches;
    bit cand_taken;
    bit cfg_taken;
    bit res_taken;
    int send_wait;
    int take_wait;
    bit send_burst;
    bit take_burst;

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic bit cut_fits(inout longint len, input longint cut);
        if (cut > len || (len - cut) < longint'(min_tile_len))
            return 1'b0;
        len -= cut;
        return 1'b1;
    endfunction

    function automatic tile_result_t trim_candidate(input stot_pkg::func_t f,
                                                    input logic [FB-1:0] ca,
                                                    input logic [FB-1:0] cb,
                                                    input logic [LB-1:0] cl);
        tile_result_t r;
        longint a;
        longint b;
        longint len;
        longint ta;
        longint tb;
        longint tl;
        bit trimmed;
        bit gone;
        r.verdict = stot_pkg::VERDICT_CLEARED;
        r.first_pos = '0;
        r.second_pos = '0;
        r.len = '0;
        if (f == stot_pkg::FUNC_CLEAR)
        begin
            kept_count = 0;
            return r;
        end
        a = longint'(ca);
        b = longint'(cb);
        len = longint'(cl);
        trimmed = 1'b0;
        gone = 1'b0;
        for (int i = 0; i < kept_count && !gone; i++)
        begin
            ta = longint'(kept_first[i]);
            tb = longint'(kept_second[i]);
            tl = longint'(kept_len[i]);
            if (a >= ta && a < ta + tl)
            begin
                if (!cut_fits(len, ta + tl - a))
                    gone = 1'b1;
                else
                begin
                    b += ta + tl - a;
                    a = ta + tl;
                    trimmed = 1'b1;
                end
            end
            else if (a + len > ta && a + len < ta + tl)
            begin
                if (!cut_fits(len, a + len - ta))
                    gone = 1'b1;
                else
                    trimmed = 1'b1;
            end
            if (!gone)
            begin
                if (b >= tb && b < tb + tl)
                begin
                    if (!cut_fits(len, tb + tl - b))
                        gone = 1'b1;
                    else
                    begin
                        a += tb + tl - b;
                        b = tb + tl;
                        trimmed = 1'b1;
                    end
                end
                else if (b + len > tb && b + len < tb + tl)
                begin
                    if (!cut_fits(len, b + len - tb))
                        gone = 1'b1;
                    else
                        trimmed = 1'b1;
                end
            end
        end
        if (gone)
        begin
            r.verdict = stot_pkg::VERDICT_DISCARD;
            return r;
        end
        if (trimmed)
            r.verdict = stot_pkg::VERDICT_TRIMMED;
        else if (kept_count >= TILE_SLOTS)
            r.verdict = stot_pkg::VERDICT_FULL;
        else
        begin
            kept_first[kept_count] = a[FB-1:0];
            kept_second[kept_count] = b[FB-1:0];
            kept_len[kept_count] = len[LB-1:0];
            kept_count++;
            r.verdict = stot_pkg::VERDICT_STORED;
        end
        r.first_pos = a[FB-1:0];
        r.second_pos = b[FB-1:0];
        r.len = len[LB-1:0];
        return r;
    endfunction

    task automatic queue_word(input word_kind_t kind, input stot_pkg::func_t f,
                              input int a, input int b, input int l);
        stim_word_t w;
        w.kind = kind;
        w.func = f;
        w.first_pos = FB'(a);
        w.second_pos = FB'(b);
        w.len = LB'(l);
        word_queue = {word_queue, w};
    endtask

    task automatic add_random_cands(input int count, input int len_cap);
        int base_a;
        int base_b;
        int off;
        int pick;
        base_a = $urandom_range(0, 60000);
        base_b = $urandom_range(0, 60000);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            off = $urandom_range(0, 1023);
            if (pick < 3)
                queue_word(WORD_CAND, stot_pkg::FUNC_CLEAR, $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 65535));
            else if (pick < 13)
                queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 65535));
            else
                queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, base_a + off,
                           base_b + off + int'($urandom_range(0, 64)) - 32,
                           $urandom_range(0, len_cap));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        cand_bus.valid = 1'b0;
        cand_bus.func = stot_pkg::FUNC_CHECK;
        cand_bus.cand_first_pos = '0;
        cand_bus.cand_second_pos = '0;
        cand_bus.cand_len = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.min_match_len = '0;
        res_bus.ready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Predictor state and result checking, sampled at the rising edge.
    initial
    begin
        kept_count = 0;
        min_tile_len = stot_pkg::MIN_LEN_RESET;
        mismatches = 0;
        cand_taken = 1'b0;
        cfg_taken = 1'b0;
        res_taken = 1'b0;
    end

    always @(posedge clk)
    begin
        tile_result_t want;
        tile_result_t fresh;
        if (rst_n)
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                res_taken = 1'b1;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected result word: verdict %0d %0d %0d %0d", $time,
                             res_bus.verdict, res_bus.out_first_pos,
                             res_bus.out_second_pos, res_bus.out_len);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (res_bus.verdict !== want.verdict)
                    begin
                        mismatches++;
                        $display("%0t verdict: expected %0d actual %0d", $time,
                                 want.verdict, res_bus.verdict);
                    end
                    if (res_bus.out_first_pos !== want.first_pos)
                    begin
                        mismatches++;
                        $display("%0t out_first_pos: expected %0d actual %0d", $time,
                                 want.first_pos, res_bus.out_first_pos);
                    end
                    if (res_bus.out_second_pos !== want.second_pos)
                    begin
                        mismatches++;
                        $display("%0t out_second_pos: expected %0d actual %0d", $time,
                                 want.second_pos, res_bus.out_second_pos);
                    end
                    if (res_bus.out_len !== want.len)
                    begin
                        mismatches++;
                        $display("%0t out_len: expected %0d actual %0d", $time,
                                 want.len, res_bus.out_len);
                    end
                end
            end
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                cfg_taken = 1'b1;
                min_tile_len = cfg_bus.min_match_len;
            end
            if (cand_bus.valid && cand_bus.ready)
            begin
                cand_taken = 1'b1;
                fresh = trim_candidate(stot_pkg::func_t'(cand_bus.func),
                                       cand_bus.cand_first_pos,
                                       cand_bus.cand_second_pos,
                                       cand_bus.cand_len);
                pending_results = {pending_results, fresh};
            end
        end
    end

    // Word driver; configuration and hold words wait until the block is idle.
    initial
    begin
        send_wait = 0;
        send_burst = 1'b0;
        take_wait = 0;
        take_burst = 1'b0;
    end

    always @(negedge clk)
    begin
        logic next_cand;
        logic next_cfg;
        stim_word_t w;
        if (rst_n)
        begin
            next_cand = cand_bus.valid;
            next_cfg = cfg_bus.valid;
            if (cand_taken)
            begin
                cand_taken = 1'b0;
                next_cand = 1'b0;
            end
            if (cfg_taken)
            begin
                cfg_taken = 1'b0;
                next_cfg = 1'b0;
            end
            if (!next_cand && !next_cfg)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (word_queue.size() > 0)
                begin
                    w = word_queue[0];
                    if (w.kind == WORD_CAND)
                    begin
                        void'(word_queue.pop_front());
                        cand_bus.func <= w.func;
                        cand_bus.cand_first_pos <= w.first_pos;
                        cand_bus.cand_second_pos <= w.second_pos;
                        cand_bus.cand_len <= w.len;
                        next_cand = 1'b1;
                        if ($urandom_range(0, 29) == 0)
                            send_burst = !send_burst;
                        send_wait = draw_wait(send_burst);
                    end
                    else if (pending_results.size() == 0)
                    begin
                        void'(word_queue.pop_front());
                        if (w.kind == WORD_CFG)
                        begin
                            cfg_bus.min_match_len <= w.len;
                            next_cfg = 1'b1;
                        end
                    end
                end
            end
            cand_bus.valid <= next_cand;
            cfg_bus.valid <= next_cfg;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_taken)
            begin
                res_taken = 1'b0;
                if ($urandom_range(0, 29) == 0)
                    take_burst = !take_burst;
                take_wait = draw_wait(take_burst);
            end
            res_bus.ready <= (take_wait == 0);
            if (take_wait > 0)
                take_wait--;
        end
    end

    initial
    begin
        int slot;

        // Directed words under the reset minimum of eight.
        queue_word(WORD_CAND, stot_pkg::FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 100, 200, 20);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 0, 0, 0);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 110, 500, 20);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 105, 600, 12);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 115, 700, 12);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 90, 800, 20);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 95, 900, 30);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 2000, 3000, 50);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 1990, 4000, 60);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 5000, 210, 20);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 6000, 190, 20);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 6100, 195, 12);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 2040, 3990, 40);
        queue_word(WORD_CAND, stot_pkg::FUNC_CLEAR, 0, 0, 0);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 65500, 30000, 100);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 65520, 40000, 200);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 0, 0, 16'hFFFF);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 1, 2, 0);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 30050, 29990, 40);

        queue_word(WORD_CFG, stot_pkg::FUNC_CHECK, 0, 0, 1);
        add_random_cands(50, 160);
        queue_word(WORD_HOLD, stot_pkg::FUNC_CHECK, 0, 0, 0);
        add_random_cands(20, 160);

        queue_word(WORD_CFG, stot_pkg::FUNC_CHECK, 0, 0, 16'hFFFF);
        queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, 10, 10, 16'hFFFF);
        add_random_cands(15, 65535);

        // Fill every slot with tiles that are disjoint on both sequences.
        queue_word(WORD_CFG, stot_pkg::FUNC_CHECK, 0, 0, 4);
        queue_word(WORD_CAND, stot_pkg::FUNC_CLEAR, 0, 0, 0);
        for (int i = 0; i < TILE_SLOTS; i++)
            queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, i * 256, i * 256,
                       $urandom_range(1, 128));
        for (int i = 0; i < 12; i++)
        begin
            slot = $urandom_range(0, TILE_SLOTS - 1);
            if (i % 2 == 0)
                queue_word(WORD_CAND, stot_pkg::FUNC_CHECK, slot * 256 + 200,
                           slot * 256 + 200, $urandom_range(0, 20));
            else
                queue_word(WORD_CAND, stot_pkg::FUNC_CHECK,
                           slot * 256 + int'($urandom_range(0, 60)),
                           slot * 256 + int'($urandom_range(0, 255)),
                           $urandom_range(0, 200));
        end
        queue_word(WORD_CAND, stot_pkg::FUNC_CLEAR, 0, 0, 0);

        queue_word(WORD_CFG, stot_pkg::FUNC_CHECK, 0, 0, $urandom_range(1, 64));
        add_random_cands(25, 200);

        while (word_queue.size() != 0 || cand_bus.valid || cfg_bus.valid ||
               pending_results.size() != 0)
            @(posedge clk);
        repeat (CHAIN_CYCLES + 20) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/stot_pkg.sv
rtl/stot_ifs.sv
rtl/stot_stage.sv
rtl/stot_cell.sv
rtl/string_tile_overlap_trimmer_unit.sv
bench/tb_string_tile_overlap_trimmer_unit.sv
